>>> rtl/core/sta_pkg.sv
// ----------------------------------------------------------------------------
// sta_pkg: shared types and constants for the sparse triplet accumulator
// Command kinds, status codes, sequencer states and table sizing.
// ----------------------------------------------------------------------------
package sta_pkg;

   localparam int SLOTS_DEFAULT = 4096;

   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_READ  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_COLROW = 2'd2,
      ST_UNUSED = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_RMW_RD,
      S_RMW_WAIT,
      S_RMW_WR,
      S_CLEAR,
      S_READ_RD,
      S_READ_WAIT,
      S_DONE
   } state_type;

   // Saturating Q16.16 add
   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) sat_add = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else sat_add = s[31:0];
   endfunction

endpackage

>>> rtl/core/sparse_triplet_accumulator_unit.sv
// ----------------------------------------------------------------------------
// sparse_triplet_accumulator_unit: COO triplet assembly with coalescing
// Sequencer around a shared entry table, replay list and saturating adder.
// ----------------------------------------------------------------------------
//  channel | dir | signals
//  req     | in  | req_tvalid, req_tready, req_tdata[79:0], req_tuser[1:0] (kind)
//  rsp     | out | rsp_tvalid, rsp_tready, rsp_tdata[95:0], rsp_tuser[1:0] (status)
//
//  One transaction at a time; req_tready is high only in idle.
//  A replayed add skips the key scan; a new key scans every used entry, a key match at
//  slot k scans entries 0 to k, and clear zeroes the value of every used entry.
//  The key scan reads one entry at a time through the single table port (SCAN_RD, SCAN_CMP).
//  A result still held at the output stalls the sequencer in DONE.
//  Synchronous reset clears counters and control; memories are not cleared.
// ----------------------------------------------------------------------------
module sparse_triplet_accumulator_unit #(
   parameter int SLOTS = sta_pkg::SLOTS_DEFAULT,
   parameter int AW    = $clog2(SLOTS)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // row[15:0], col[31:16], value[63:32], read_slot[63+AW:64], zero fill
   input  logic [79:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // slot[11:0], new_entry[12], entry_row[28:13], entry_col[44:29],
   // entry_value[76:45], unique_count[89:77], zero fill
   output logic [95:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser
);

   localparam int CW = AW + 1;

   sta_pkg::state_type state_ff, state_in;

   logic [1:0]    kind_ff;
   logic [15:0]   row_ff, col_ff;
   logic [31:0]   value_ff;
   logic [AW-1:0] rslot_ff;
   logic [CW-1:0] add_cnt_ff, add_cnt_in;
   logic [CW-1:0] long_cnt_ff, long_cnt_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic          newe_ff, newe_in;
   logic [1:0]    st_ff, st_in;
   logic [15:0]   orow_ff, orow_in, ocol_ff, ocol_in;
   logic [31:0]   oval_ff, oval_in;
   logic          ovalid_ff;
   logic [95:0]   odata_ff;
   logic [1:0]    ostat_ff;
   logic          load_out;
   logic [11:0]   slot_field;
   logic [12:0]   count_field;

   logic [AW-1:0] ent_addr, rep_addr, rep_wd, rep_rd;
   logic          key_we, val_we, rep_we;
   logic [15:0]   row_wd, col_wd, row_rd, col_rd;
   logic [31:0]   val_wd, val_rd;
   logic [31:0]   sum;

   sta_table #(.SLOTS(SLOTS), .AW(AW)) u_table (
      .clock(clock), .ent_addr(ent_addr), .key_we(key_we), .val_we(val_we),
      .row_wd(row_wd), .col_wd(col_wd), .val_wd(val_wd),
      .row_rd(row_rd), .col_rd(col_rd), .val_rd(val_rd),
      .rep_addr(rep_addr), .rep_we(rep_we), .rep_wd(rep_wd), .rep_rd(rep_rd)
   );

   assign req_tready  = (state_ff == sta_pkg::S_IDLE);
   assign rsp_tvalid  = ovalid_ff;
   assign rsp_tuser   = ostat_ff;
   assign rsp_tdata   = odata_ff;
   assign load_out    = (state_ff == sta_pkg::S_DONE) && (!ovalid_ff || rsp_tready);
   assign slot_field  = 12'(slot_ff);
   assign count_field = 13'(used_ff);
   assign sum = sta_pkg::sat_add(val_rd, value_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sta_pkg::S_IDLE:
            if (req_tvalid) state_in = sta_pkg::S_DECODE;
         sta_pkg::S_DECODE: begin
            priority case (kind_ff)
               sta_pkg::KIND_ADD: begin
                  if (col_ff > row_ff || add_cnt_ff >= CW'(SLOTS))
                     state_in = sta_pkg::S_DONE;
                  else if (add_cnt_ff < long_cnt_ff) state_in = sta_pkg::S_RMW_RD;
                  else state_in = sta_pkg::S_SCAN_RD;
               end
               sta_pkg::KIND_CLEAR: state_in = sta_pkg::S_CLEAR;
               sta_pkg::KIND_READ:
                  state_in = ({1'b0, rslot_ff} >= used_ff) ? sta_pkg::S_DONE
                                                          : sta_pkg::S_READ_RD;
               default: state_in = sta_pkg::S_DONE;
            endcase
         end
         sta_pkg::S_SCAN_RD:
            state_in = (idx_ff >= used_ff) ? sta_pkg::S_DONE : sta_pkg::S_SCAN_CMP;
         sta_pkg::S_SCAN_CMP:
            state_in = (row_rd == row_ff && col_rd == col_ff) ? sta_pkg::S_RMW_WAIT
                                                              : sta_pkg::S_SCAN_RD;
         sta_pkg::S_RMW_RD:    state_in = sta_pkg::S_RMW_WAIT;
         sta_pkg::S_RMW_WAIT:  state_in = sta_pkg::S_RMW_WR;
         sta_pkg::S_RMW_WR:    state_in = sta_pkg::S_DONE;
         sta_pkg::S_CLEAR:
            if (idx_ff >= used_ff) state_in = sta_pkg::S_DONE;
         sta_pkg::S_READ_RD:   state_in = sta_pkg::S_READ_WAIT;
         sta_pkg::S_READ_WAIT: state_in = sta_pkg::S_DONE;
         sta_pkg::S_DONE:
            if (!ovalid_ff || rsp_tready) state_in = sta_pkg::S_IDLE;
         default: state_in = sta_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      add_cnt_in  = add_cnt_ff;
      long_cnt_in = long_cnt_ff;
      used_in     = used_ff;
      idx_in      = idx_ff;
      slot_in     = slot_ff;
      newe_in     = newe_ff;
      st_in       = st_ff;
      orow_in     = orow_ff;
      ocol_in     = ocol_ff;
      oval_in     = oval_ff;
      ent_addr    = idx_ff[AW-1:0];
      rep_addr    = add_cnt_ff[AW-1:0];
      key_we      = 1'b0;
      val_we      = 1'b0;
      rep_we      = 1'b0;
      row_wd      = row_ff;
      col_wd      = col_ff;
      val_wd      = sum;
      rep_wd      = slot_ff;
      unique case (state_ff)
         sta_pkg::S_IDLE: begin
         end
         sta_pkg::S_DECODE: begin
            idx_in  = '0;
            slot_in = '0;
            newe_in = 1'b0;
            orow_in = '0;
            ocol_in = '0;
            oval_in = '0;
            st_in   = sta_pkg::ST_OK;
            if (kind_ff == sta_pkg::KIND_ADD) begin
               if (col_ff > row_ff) st_in = sta_pkg::ST_COLROW;
               else if (add_cnt_ff >= CW'(SLOTS)) st_in = sta_pkg::ST_FULL;
            end else if (kind_ff == sta_pkg::KIND_READ) begin
               slot_in = rslot_ff;
               if ({1'b0, rslot_ff} >= used_ff) st_in = sta_pkg::ST_UNUSED;
            end else if (kind_ff == sta_pkg::KIND_CLEAR) begin
               add_cnt_in = '0;
            end
         end
         sta_pkg::S_SCAN_RD: begin
            if (idx_ff >= used_ff) begin
               // miss: append a new entry, or report full if no slot is free
               if (used_ff >= CW'(SLOTS)) begin
                  st_in = sta_pkg::ST_FULL;
               end else begin
                  ent_addr = used_ff[AW-1:0];
                  key_we   = 1'b1;
                  val_we   = 1'b1;
                  val_wd   = value_ff;
                  rep_we   = 1'b1;
                  rep_wd   = used_ff[AW-1:0];
                  slot_in  = used_ff[AW-1:0];
                  newe_in  = 1'b1;
                  orow_in  = row_ff;
                  ocol_in  = col_ff;
                  oval_in  = value_ff;
                  used_in  = used_ff + 1'b1;
                  add_cnt_in = add_cnt_ff + 1'b1;
                  if (add_cnt_ff + 1'b1 > long_cnt_ff) long_cnt_in = add_cnt_ff + 1'b1;
               end
            end
         end
         sta_pkg::S_SCAN_CMP: begin
            ent_addr = idx_ff[AW-1:0];
            slot_in  = idx_ff[AW-1:0];
            if (!(row_rd == row_ff && col_rd == col_ff)) idx_in = idx_ff + 1'b1;
            else begin
               rep_we = 1'b1;
               rep_wd = idx_ff[AW-1:0];
            end
         end
         sta_pkg::S_RMW_RD: begin
         end
         sta_pkg::S_RMW_WAIT: begin
            if (kind_ff == sta_pkg::KIND_ADD && add_cnt_ff < long_cnt_ff &&
                newe_ff == 1'b0 && idx_ff == '0 && slot_ff == '0)
               slot_in = rep_rd;
            ent_addr = (add_cnt_ff < long_cnt_ff) ? rep_rd : slot_ff;
            if (add_cnt_ff < long_cnt_ff) slot_in = rep_rd;
         end
         sta_pkg::S_RMW_WR: begin
            ent_addr = slot_ff;
            val_we   = 1'b1;
            orow_in  = row_rd;
            ocol_in  = col_rd;
            oval_in  = sum;
            add_cnt_in = add_cnt_ff + 1'b1;
            if (add_cnt_ff + 1'b1 > long_cnt_ff) long_cnt_in = add_cnt_ff + 1'b1;
         end
         sta_pkg::S_CLEAR: begin
            if (idx_ff < used_ff) begin
               val_we = 1'b1;
               val_wd = '0;
               idx_in = idx_ff + 1'b1;
            end
         end
         sta_pkg::S_READ_RD: begin
            ent_addr = rslot_ff;
         end
         sta_pkg::S_READ_WAIT: begin
            ent_addr = rslot_ff;
            orow_in  = row_rd;
            ocol_in  = col_rd;
            oval_in  = val_rd;
         end
         sta_pkg::S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sta_pkg::S_IDLE;
         add_cnt_ff  <= '0;
         long_cnt_ff <= '0;
         used_ff     <= '0;
         ovalid_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         add_cnt_ff  <= add_cnt_in;
         long_cnt_ff <= long_cnt_in;
         used_ff     <= used_in;
         if (load_out) ovalid_ff <= 1'b1;
         else if (rsp_tready) ovalid_ff <= 1'b0;
      end
   end

   // Capture the request on accept; in DONE, load the result once the previous one is gone.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff  <= req_tuser;
         row_ff   <= req_tdata[15:0];
         col_ff   <= req_tdata[31:16];
         value_ff <= req_tdata[63:32];
         rslot_ff <= req_tdata[64 +: AW];
      end
      if (load_out) begin
         odata_ff <= {6'b0, count_field, oval_ff, ocol_ff, orow_ff, newe_ff, slot_field};
         ostat_ff <= st_ff;
      end
      idx_ff  <= idx_in;
      slot_ff <= slot_in;
      newe_ff <= newe_in;
      st_ff   <= st_in;
      orow_ff <= orow_in;
      ocol_ff <= ocol_in;
      oval_ff <= oval_in;
   end

endmodule

>>> rtl/core/sta_table.sv
// ----------------------------------------------------------------------------
// sta_table: entry table and replay list storage
// Single-port style memories with registered read data.
// ----------------------------------------------------------------------------
module sta_table #(
   parameter int SLOTS = sta_pkg::SLOTS_DEFAULT,
   parameter int AW    = $clog2(SLOTS)
) (
   input  logic          clock,
   input  logic [AW-1:0] ent_addr,
   input  logic          key_we,
   input  logic          val_we,
   input  logic [15:0]   row_wd,
   input  logic [15:0]   col_wd,
   input  logic [31:0]   val_wd,
   output logic [15:0]   row_rd,
   output logic [15:0]   col_rd,
   output logic [31:0]   val_rd,
   input  logic [AW-1:0] rep_addr,
   input  logic          rep_we,
   input  logic [AW-1:0] rep_wd,
   output logic [AW-1:0] rep_rd
);

   logic [15:0]   key_row_mem [SLOTS];
   logic [15:0]   key_col_mem [SLOTS];
   logic [31:0]   value_mem   [SLOTS];
   logic [AW-1:0] replay_mem  [SLOTS];

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_row_mem[ent_addr] <= row_wd;
         key_col_mem[ent_addr] <= col_wd;
      end
      if (val_we) begin
         value_mem[ent_addr] <= val_wd;
      end
      row_rd <= key_row_mem[ent_addr];
      col_rd <= key_col_mem[ent_addr];
      val_rd <= value_mem[ent_addr];
   end

   always_ff @(posedge clock) begin
      if (rep_we) begin
         replay_mem[rep_addr] <= rep_wd;
      end
      rep_rd <= replay_mem[rep_addr];
   end

endmodule
